@@ sv/page_frame_allocator_core_assert.svh @@
// Assertion helpers used by the allocator RTL.
`ifndef PAGE_FRAME_ALLOCATOR_CORE_ASSERT_SVH
`define PAGE_FRAME_ALLOCATOR_CORE_ASSERT_SVH

// Clocked implication check, disabled while reset is held.
`define PFA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition seen at one edge leads to another at the next edge.
`define PFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/pfa_pkg.sv @@
package pfa_pkg;

  // Fixed field widths.
  localparam int unsigned ADDR_W   = 24;
  localparam int unsigned REG_W    = 13;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned CMP_W    = 17;
  localparam int unsigned IN_DW    = 24;
  localparam int unsigned OUT_DW   = 32;

  // Default geometry.
  localparam int unsigned PAGE_BITS_DEF = 12;
  localparam int unsigned MAX_PAGES_DEF = 4096;

  // Reset values of the configuration registers.
  localparam logic [REG_W-1:0] RSV_START_RST = 13'd0;
  localparam logic [REG_W-1:0] LIMIT_RST     = 13'd4096;

  // Request kinds.
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // Configuration register indexes.
  localparam logic REG_RSV_START = 1'b0;
  localparam logic REG_LIMIT     = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_OOM      = 2'd1,
    STAT_BAD_FREE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_POP
  } state_e;

endpackage

@@ sv/page_frame_allocator_core.sv @@
// Page frame allocator: a LIFO free list in front of a bump pointer. Each request item
// (tuser: 0 allocate, 1 free) produces exactly one result item carrying a page address and a
// status. Frees, bump allocations and out-of-memory answers load the result register as they
// run; a free-list allocation reads the next head from the registered link memory and loads
// the result in the pop state. A request that meets a held result register is parked in an
// input register and runs once the result leaves. The link memory holds one word per page and
// needs no clearing after reset, since every link is written by a free before an allocation
// can read it. Writing reserved_start_page restarts the bump pointer and empties the free
// list; configuration must be written while the block is idle; the block does not enforce it.
`include "page_frame_allocator_core_assert.svh"

module page_frame_allocator_core
  import pfa_pkg::*;
#(
  parameter int unsigned PAGE_BITS = PAGE_BITS_DEF,
  parameter int unsigned MAX_PAGES = MAX_PAGES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Request stream.
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [IN_DW-1:0]  s_axis_tdata,   // [23:0] free_address
  input  logic              s_axis_tuser,   // [0] action
  // Result stream.
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_DW-1:0] m_axis_tdata,   // [23:0] page_address, [25:24] status, rest zero
  // Configuration writes.
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [REG_W-1:0]  cfg_wdata_i
);

  localparam int unsigned PG_W  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int unsigned SH_W  = CMP_W + ADDR_W;
  localparam int unsigned REACH_PAGES = 1 << (ADDR_W - PAGE_BITS);
  localparam logic [CMP_W-1:0] REACH =
      CMP_W'((MAX_PAGES < REACH_PAGES) ? MAX_PAGES : REACH_PAGES);
  localparam logic [ADDR_W-1:0] OFFS_MASK = ADDR_W'((1 << PAGE_BITS) - 1);

  // Control and configuration state.
  state_e             state_q, state_d;
  logic [REG_W-1:0]   rsv_q;
  logic [REG_W-1:0]   lim_q;
  logic [REG_W-1:0]   bump_q, bump_d;
  logic [PG_W-1:0]    head_q, head_d;
  logic               lvalid_q, lvalid_d;

  // Parked request.
  logic               item_act_q;
  logic [ADDR_W-1:0]  item_addr_q;

  // Result register.
  logic               out_valid_q;
  logic [ADDR_W-1:0]  out_addr_q, out_addr_d;
  status_e            out_stat_q, out_stat_d;
  logic               out_load;

  // Link memory: {valid, next page} per page.
  logic [PG_W:0]      link_mem [MAX_PAGES];
  logic [PG_W:0]      rd_q;
  logic               mem_we, mem_re;
  logic [PG_W-1:0]    wr_idx;

  // Request decode.
  logic               in_acc, slot_free, exec, pop_start;
  logic               cur_act;
  logic [ADDR_W-1:0]  cur_addr;
  logic [CMP_W-1:0]   eff_lim, fr_page;
  logic               fr_ok, bump_ok;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign slot_free = !out_valid_q || m_axis_tready;
  assign cur_act   = (state_q == ST_IDLE) ? s_axis_tuser : item_act_q;
  assign cur_addr  = (state_q == ST_IDLE) ? s_axis_tdata[ADDR_W-1:0] : item_addr_q;
  assign exec      = ((state_q == ST_IDLE && in_acc) || state_q == ST_EXEC) && slot_free;
  assign pop_start = (cur_act == ACT_ALLOC) && lvalid_q;

  // Effective limit and range checks.
  assign eff_lim = (CMP_W'(lim_q) < REACH) ? CMP_W'(lim_q) : REACH;
  assign fr_page = CMP_W'(cur_addr >> PAGE_BITS);
  assign fr_ok   = ((cur_addr & OFFS_MASK) == '0) && (fr_page >= CMP_W'(rsv_q)) &&
                   (fr_page < eff_lim);
  assign bump_ok = CMP_W'(bump_q) < eff_lim;
  assign wr_idx  = fr_page[PG_W-1:0];

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (!slot_free) state_d = ST_EXEC;
          else if (pop_start) state_d = ST_POP;
        end
      end
      ST_EXEC: begin
        if (slot_free) state_d = pop_start ? ST_POP : ST_IDLE;
      end
      ST_POP:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Request execution and result values.
  always_comb begin
    out_load   = 1'b0;
    out_addr_d = '0;
    out_stat_d = STAT_OK;
    head_d     = head_q;
    lvalid_d   = lvalid_q;
    bump_d     = bump_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    unique case (state_q)
      ST_IDLE, ST_EXEC: begin
        if (exec) begin
          if (pop_start) begin
            mem_re = 1'b1;
          end else if (cur_act == ACT_ALLOC) begin
            out_load = 1'b1;
            if (bump_ok) begin
              out_addr_d = ADDR_W'(SH_W'(bump_q) << PAGE_BITS);
              bump_d     = bump_q + REG_W'(1);
            end else begin
              out_stat_d = STAT_OOM;
            end
          end else begin
            out_load = 1'b1;
            if (fr_ok) begin
              mem_we   = 1'b1;
              head_d   = wr_idx;
              lvalid_d = 1'b1;
            end else begin
              out_stat_d = STAT_BAD_FREE;
            end
          end
        end
      end
      ST_POP: begin
        out_load   = 1'b1;
        out_addr_d = ADDR_W'(SH_W'(head_q) << PAGE_BITS);
        head_d     = rd_q[PG_W-1:0];
        lvalid_d   = rd_q[PG_W];
      end
      default: ;
    endcase
    // Writing the start register restarts the bump pointer and empties the list.
    if (cfg_we_i && cfg_idx_i == REG_RSV_START) begin
      bump_d   = cfg_wdata_i;
      lvalid_d = 1'b0;
    end
  end

  // Control registers and configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rsv_q       <= RSV_START_RST;
      lim_q       <= LIMIT_RST;
      bump_q      <= RSV_START_RST;
      head_q      <= '0;
      lvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      bump_q   <= bump_d;
      head_q   <= head_d;
      lvalid_q <= lvalid_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_RSV_START: rsv_q <= cfg_wdata_i;
          REG_LIMIT:     lim_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_act_q  <= s_axis_tuser;
      item_addr_q <= s_axis_tdata[ADDR_W-1:0];
    end
    if (out_load) begin
      out_addr_q <= out_addr_d;
      out_stat_q <= out_stat_d;
    end
  end

  // Link memory: push writes the old head, pop reads the link of the head.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[wr_idx] <= {lvalid_q, head_q};
    end
    if (mem_re) begin
      rd_q <= link_mem[head_q];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_DW - ADDR_W - STAT_W){1'b0}}, out_stat_q, out_addr_q};

  // A new result never overwrites one that has not been taken.
  `PFA_ASSERT_IMPL(a_no_overwrite, out_load, !out_valid_q || m_axis_tready, "result overwritten")
  // The pop cycle always follows a link read of a nonempty list.
  `PFA_ASSERT_IMPL(a_pop_after_read, state_q == ST_POP, $past(mem_re) && $past(lvalid_q), "pop without read")
  // Only accepted pages are pushed, and they lie inside the managed range.
  `PFA_ASSERT_IMPL(a_push_range, mem_we, fr_page < eff_lim && fr_page >= CMP_W'(rsv_q), "bad push")
  // A refused request carries a zero address.
  `PFA_ASSERT_IMPL(a_err_zero, out_valid_q && out_stat_q != STAT_OK, out_addr_q == '0, "error with address")
  // A link read always produces a result in the next cycle.
  `PFA_ASSERT_NEXT(a_read_to_result, mem_re, out_load && state_q == ST_POP, "lost pop")

endmodule

@@ tb/sv/page_frame_allocator_core_checker.sv @@
`timescale 1ns / 1ps

module page_frame_allocator_core_checker
  import pfa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  input  logic [IN_DW-1:0]  s_axis_tdata,   // [23:0] free_address
  input  logic              s_axis_tuser,   // [0] action
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic [OUT_DW-1:0] m_axis_tdata,   // [23:0] page_address, [25:24] status, rest zero
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [REG_W-1:0]  cfg_wdata_i,
  output int unsigned       error_count_o,
  output int unsigned       pending_o
);

  // Number of pages that a full byte address can reach.
  localparam logic [REG_W:0] PAGE_REACH = 14'(1 << (ADDR_W - PAGE_BITS_DEF));

  typedef struct packed {
    logic [ADDR_W-1:0] page_addr;
    status_e           status;
  } grant_t;

  // Results still owed by the block, oldest first.
  grant_t grant_q[$];

  // Shadow copy of the allocator state.
  logic [REG_W-1:0] rsv_start;
  logic [REG_W-1:0] limit_pg;
  logic [REG_W-1:0] bump_top;
  logic [REG_W-1:0] head_page;
  logic             head_valid;
  logic [REG_W-1:0] link_page [MAX_PAGES_DEF];
  logic             link_valid [MAX_PAGES_DEF];

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    error_count_o++;
  endtask

  // Apply one request to the shadow state and return the result it must produce.
  function automatic grant_t predict_grant(logic act, logic [ADDR_W-1:0] addr);
    grant_t          g;
    logic [REG_W:0]  lim_eff;
    logic [REG_W:0]  page;
    g.page_addr = '0;
    g.status    = STAT_OK;
    lim_eff = (limit_pg > MAX_PAGES_DEF) ? 14'(MAX_PAGES_DEF) : {1'b0, limit_pg};
    if (lim_eff > PAGE_REACH) lim_eff = PAGE_REACH;
    if (act == ACT_ALLOC) begin
      if (head_valid && head_page < MAX_PAGES_DEF) begin
        // Pop the most recently freed page.
        g.page_addr = ADDR_W'(32'(head_page) << PAGE_BITS_DEF);
        head_valid  = link_valid[head_page];
        head_page   = link_page[head_page];
      end else if (bump_top < lim_eff) begin
        g.page_addr = ADDR_W'(32'(bump_top) << PAGE_BITS_DEF);
        bump_top    = bump_top + 1'b1;
      end else begin
        g.status = STAT_OOM;
      end
    end else begin
      page = 14'(addr >> PAGE_BITS_DEF);
      if (addr[PAGE_BITS_DEF-1:0] != '0 || page < rsv_start || page >= lim_eff ||
          page >= MAX_PAGES_DEF) begin
        g.status = STAT_BAD_FREE;
      end else begin
        // Push; a double free simply links the page again.
        link_page[page]  = head_page;
        link_valid[page] = head_valid;
        head_page        = REG_W'(page);
        head_valid       = 1'b1;
      end
    end
    return g;
  endfunction

  task automatic check_result();
    grant_t want;
    if (grant_q.size() == 0) begin
      report_mismatch("result item with nothing expected", m_axis_tdata, '0);
    end else begin
      want = grant_q.pop_front();
      if (m_axis_tdata[ADDR_W-1:0] !== want.page_addr)
        report_mismatch("page_address", m_axis_tdata[ADDR_W-1:0], want.page_addr);
      if (m_axis_tdata[ADDR_W+STAT_W-1:ADDR_W] !== want.status)
        report_mismatch("status", m_axis_tdata[ADDR_W+STAT_W-1:ADDR_W], want.status);
      if (m_axis_tdata[OUT_DW-1:ADDR_W+STAT_W] !== '0)
        report_mismatch("padding bits", m_axis_tdata[OUT_DW-1:ADDR_W+STAT_W], '0);
    end
  endtask

  // Watch all three channels at each rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsv_start     = RSV_START_RST;
      limit_pg      = LIMIT_RST;
      bump_top      = RSV_START_RST;
      head_page     = '0;
      head_valid    = 1'b0;
      error_count_o = 0;
      grant_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (s_axis_tvalid && s_axis_tready)
        grant_q.push_back(predict_grant(s_axis_tuser, s_axis_tdata[ADDR_W-1:0]));
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_RSV_START) begin
          // Restart the bump pointer and drop the free list.
          rsv_start  = cfg_wdata_i;
          bump_top   = cfg_wdata_i;
          head_page  = '0;
          head_valid = 1'b0;
        end else begin
          limit_pg = cfg_wdata_i;
        end
      end
    end
    pending_o = grant_q.size();
  end

endmodule

@@ tb/sv/page_frame_allocator_core_test.sv @@
`timescale 1ns / 1ps

module page_frame_allocator_core_test;
  import pfa_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_DW-1:0]  s_axis_tdata = '0;   // [23:0] free_address
  logic              s_axis_tuser = 1'b0; // [0] action
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_DW-1:0] m_axis_tdata;        // [23:0] page_address, [25:24] status, rest zero
  logic              cfg_we_i = 1'b0;
  logic              cfg_idx_i = REG_RSV_START;
  logic [REG_W-1:0]  cfg_wdata_i = '0;

  int unsigned error_count;
  int unsigned outstanding;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_cycles = 0;

  // Register values as last written, used to aim the free requests.
  logic [REG_W-1:0] cur_rsv = RSV_START_RST;
  logic [REG_W-1:0] cur_lim = LIMIT_RST;

  page_frame_allocator_core #(
    .PAGE_BITS(PAGE_BITS_DEF),
    .MAX_PAGES(MAX_PAGES_DEF)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  page_frame_allocator_core_checker alloc_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .error_count_o(error_count),
    .pending_o    (outstanding)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("page_frame_allocator_core_test: done, errors");
      $finish;
    end
  end

  // Result side: a long hold-off when asked, random stalls otherwise.
  always @(negedge clk_i) begin
    if (hold_cycles != 0) begin
      hold_cycles--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offer one request item and return at the falling edge after it is taken.
  task automatic send_item(logic act, logic [ADDR_W-1:0] addr);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= addr;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Stop offering and wait until every result has come back.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [REG_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    if (idx == REG_RSV_START) cur_rsv = value;
    else cur_lim = value;
  endtask

  task automatic set_config(logic [REG_W-1:0] rsv, logic [REG_W-1:0] lim);
    wait_idle();
    write_reg(REG_LIMIT, lim);
    write_reg(REG_RSV_START, rsv);
  endtask

  // Mostly well-formed traffic: allocations and aligned frees near the valid range,
  // with some misaligned and fully random addresses mixed in.
  task automatic random_item();
    int unsigned pick;
    int unsigned lim_eff;
    int unsigned lo;
    int unsigned hi;
    int unsigned page;
    pick    = $urandom_range(99);
    lim_eff = (cur_lim > MAX_PAGES_DEF) ? MAX_PAGES_DEF : cur_lim;
    lo      = (cur_rsv > 0) ? cur_rsv - 1 : 0;
    hi      = (lim_eff < MAX_PAGES_DEF) ? lim_eff : MAX_PAGES_DEF - 1;
    if (pick < 45) begin
      send_item(ACT_ALLOC, ADDR_W'($urandom));
    end else if (pick < 85 && cur_rsv < lim_eff && lo <= hi) begin
      page = $urandom_range(hi, lo);
      send_item(ACT_FREE, ADDR_W'(page << PAGE_BITS_DEF));
    end else if (pick < 93) begin
      send_item(ACT_FREE, {12'($urandom), 12'($urandom_range(4095, 1))});
    end else begin
      send_item(ACT_FREE, ADDR_W'($urandom));
    end
  endtask

  task automatic run_phase(logic [REG_W-1:0] rsv, logic [REG_W-1:0] lim,
                           int unsigned idle, int unsigned stall, int unsigned count);
    set_config(rsv, lim);
    send_idle_pct = idle;
    stall_pct     = stall;
    repeat (count) random_item();
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Bump allocation, then frees popped back in LIFO order.
    send_item(ACT_ALLOC, 24'hFFFFFF);
    send_item(ACT_ALLOC, 24'h000000);
    send_item(ACT_FREE, 24'h000000);
    send_item(ACT_FREE, 24'h001000);
    send_item(ACT_ALLOC, 24'h000000);
    send_item(ACT_ALLOC, 24'h000000);
    send_item(ACT_ALLOC, 24'h000000);
    // Top page, misaligned frees, and a double free of the top page.
    send_item(ACT_FREE, 24'hFFF000);
    send_item(ACT_FREE, 24'hFFFFFF);
    send_item(ACT_FREE, 24'h000800);
    send_item(ACT_FREE, 24'hFFF000);
    send_item(ACT_ALLOC, 24'h000000);
    send_item(ACT_ALLOC, 24'h000000);
    send_item(ACT_ALLOC, 24'h000000);

    // Narrow window at the top of memory: below-start free, then exhaustion.
    set_config(13'd4094, 13'd4096);
    send_item(ACT_FREE, 24'hFFD000);
    send_item(ACT_ALLOC, 24'h000000);
    send_item(ACT_ALLOC, 24'h000000);
    send_item(ACT_ALLOC, 24'h000000);
    send_item(ACT_FREE, 24'hFFE000);

    // Limit lowered with a page still listed: the listed page is still handed out.
    wait_idle();
    write_reg(REG_LIMIT, 13'd0);
    send_item(ACT_ALLOC, 24'h000000);
    send_item(ACT_ALLOC, 24'h000000);
    send_item(ACT_FREE, 24'hFFE000);

    // Bump pointer far beyond any limit.
    set_config(13'h1FFF, 13'h1FFF);
    send_item(ACT_ALLOC, 24'h000000);
    send_item(ACT_FREE, 24'h000000);

    // Random traffic under several settings and idling patterns.
    run_phase(13'd16, 13'd48, 0, 0, 170);
    run_phase(13'd0, 13'd4096, 48, 0, 170);
    run_phase(13'd4000, 13'h1FFF, 0, 48, 170);
    run_phase(13'd200, 13'd210, 31, 31, 170);

    // Back pressure: the result side holds off while requests keep coming,
    // then the request side pauses until everything has drained.
    set_config(13'd1, 13'd30);
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_cycles   = 300;
    repeat (60) random_item();
    wait_idle();
    repeat (60) random_item();

    run_phase(13'd4096, 13'd4096, 48, 48, 60);
    run_phase(13'd0, 13'd1, 31, 31, 60);

    wait_idle();
    repeat (8) @(negedge clk_i);
    if (error_count == 0) begin
      $display("page_frame_allocator_core_test: done, clean");
    end else begin
      $display("page_frame_allocator_core_test: done, errors");
    end
    $finish;
  end

endmodule
